/* rtl/ccfr_pkg.sv */
// Shared types, codes and the CRC-8 byte step for the COBS frame receiver.
package ccfr_pkg;

  typedef enum logic [1:0] {
    KIND_ID      = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ACCEPT  = 2'd2,
    KIND_REJECT  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_CRC       = 3'd1,
    ERR_MALFORMED = 3'd2,
    ERR_OVERFLOW  = 3'd3,
    ERR_SHORT     = 3'd4
  } err_t;

  localparam logic [7:0] CODE_FULL = 8'hff;
  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam logic [7:0] COUNT_MAX = 8'hff;

  // Decoded event handed from the front end to the back end.
  typedef struct packed {
    logic       is_end;    // frame delimiter seen
    logic [7:0] data;      // decoded byte when not an end
    err_t       err;       // front-end verdict on an end (none, malformed, overflow)
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    err_t       err;
    logic [7:0] payload_count;
  } result_t;

  // CRC-8, MSB first, one byte.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] v);
    logic [7:0] c;
    c = crc ^ v;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/ccfr_fifo.sv */
// Small first-in first-out queue of packed words.
module ccfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

/* rtl/ccfr_front.sv */
// Front end: COBS block tracking, raw byte limit and fault capture.
module ccfr_front #(
  parameter int MAX_RAW_BYTES = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic [7:0]         in_byte,
  output logic               in_full,
  output logic               cmd_push,
  output ccfr_pkg::cmd_t     cmd,
  input  logic               cmd_full
);
  import ccfr_pkg::*;

  logic [7:0] blk_rem_r, blk_rem_nxt;
  logic       zero_pend_r, zero_pend_nxt;
  logic [7:0] raw_cnt_r, raw_cnt_nxt;
  err_t       fault_r, fault_nxt;
  logic       accept;

  assign in_full = cmd_full;
  assign accept  = in_push && !cmd_full;

  always_comb begin
    blk_rem_nxt   = blk_rem_r;
    zero_pend_nxt = zero_pend_r;
    raw_cnt_nxt   = raw_cnt_r;
    fault_nxt     = fault_r;
    cmd_push      = 1'b0;
    cmd.is_end    = 1'b0;
    cmd.data      = in_byte;
    cmd.err       = ERR_NONE;
    if (accept) begin
      if (in_byte == 8'h00) begin
        cmd_push   = 1'b1;
        cmd.is_end = 1'b1;
        cmd.data   = 8'h00;
        if (fault_r != ERR_NONE) begin
          cmd.err = fault_r;
        end else if (blk_rem_r != 8'h00) begin
          cmd.err = ERR_MALFORMED;
        end
        blk_rem_nxt   = 8'h00;
        zero_pend_nxt = 1'b0;
        raw_cnt_nxt   = 8'h00;
        fault_nxt     = ERR_NONE;
      end else if (fault_r != ERR_NONE) begin
        // faulted frame: swallow bytes until the delimiter
      end else if (raw_cnt_r >= 8'(MAX_RAW_BYTES)) begin
        fault_nxt = ERR_OVERFLOW;
      end else begin
        raw_cnt_nxt = raw_cnt_r + 8'd1;
        if (blk_rem_r == 8'h00) begin
          // code byte: release the implied zero of the previous block
          cmd_push      = zero_pend_r;
          cmd.data      = 8'h00;
          blk_rem_nxt   = in_byte - 8'd1;
          zero_pend_nxt = (in_byte != CODE_FULL);
        end else begin
          cmd_push    = 1'b1;
          blk_rem_nxt = blk_rem_r - 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_rem_r   <= '0;
      zero_pend_r <= 1'b0;
      raw_cnt_r   <= '0;
      fault_r     <= ERR_NONE;
    end else begin
      blk_rem_r   <= blk_rem_nxt;
      zero_pend_r <= zero_pend_nxt;
      raw_cnt_r   <= raw_cnt_nxt;
      fault_r     <= fault_nxt;
    end
  end

endmodule

/* rtl/ccfr_back.sv */
// Back end: decoded byte counting, CRC check and result formation.
module ccfr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_empty,
  input  ccfr_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_push,
  output ccfr_pkg::result_t   res
);
  import ccfr_pkg::*;

  logic [7:0] dec_cnt_r, dec_cnt_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] rx_crc_r, rx_crc_nxt;
  err_t       end_err;

  assign cmd_pop = !cmd_empty && !res_full;

  always_comb begin
    if (cmd.err != ERR_NONE) begin
      end_err = cmd.err;
    end else if (dec_cnt_r < 8'd2) begin
      end_err = ERR_SHORT;
    end else if (rx_crc_r != crc_r) begin
      end_err = ERR_CRC;
    end else begin
      end_err = ERR_NONE;
    end
  end

  always_comb begin
    dec_cnt_nxt       = dec_cnt_r;
    crc_nxt           = crc_r;
    rx_crc_nxt        = rx_crc_r;
    res_push          = 1'b0;
    res.data          = cmd.data;
    res.kind          = KIND_PAYLOAD;
    res.err           = ERR_NONE;
    res.payload_count = 8'h00;
    if (cmd_pop) begin
      if (cmd.is_end) begin
        res_push          = 1'b1;
        res.data          = 8'h00;
        res.kind          = (end_err == ERR_NONE) ? KIND_ACCEPT : KIND_REJECT;
        res.err           = end_err;
        res.payload_count = (dec_cnt_r >= 8'd2) ? dec_cnt_r - 8'd2 : 8'h00;
        dec_cnt_nxt       = 8'h00;
        crc_nxt           = 8'h00;
        rx_crc_nxt        = 8'h00;
      end else begin
        if (dec_cnt_r != COUNT_MAX) begin
          dec_cnt_nxt = dec_cnt_r + 8'd1;
        end
        if (dec_cnt_r == 8'd0) begin
          // first decoded byte carries the frame CRC
          rx_crc_nxt = cmd.data;
        end else begin
          crc_nxt  = crc8_step(crc_r, cmd.data);
          res_push = 1'b1;
          res.kind = (dec_cnt_r == 8'd1) ? KIND_ID : KIND_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_cnt_r <= '0;
      crc_r     <= '0;
      rx_crc_r  <= '0;
    end else begin
      dec_cnt_r <= dec_cnt_nxt;
      crc_r     <= crc_nxt;
      rx_crc_r  <= rx_crc_nxt;
    end
  end

endmodule

/* rtl/cobs_crc8_frame_receiver.sv */
// Top level of the COBS frame receiver with CRC-8 check.
//
//   channel  | ports                                             | transfer when
//   ---------+---------------------------------------------------+---------------------
//   input    | in_byte, in_push, in_full                         | in_push && !in_full
//   result   | out_byte, out_kind, out_error_code,               | out_pop && !out_empty
//            | out_payload_count, out_empty, out_pop             |
//
// One raw byte per cycle while in_full is low; a byte's result is registered in the
// event queue and then the result queue before it shows on the result ports (front
// end into a 2-entry event queue, back end into a 2-entry result queue). Each stage
// takes one byte per cycle while its output queue has room; CRC-8 runs combinationally.
// Synchronous active-low reset empties both queues and clears the frame state.
// A stalled result side fills the result queue, then the event queue, then
// raises in_full; bytes that produce no event are still taken while space remains.
module cobs_crc8_frame_receiver #(
  parameter int MAX_RAW_BYTES = 255
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_byte,
  input  logic                 in_push,
  output logic                 in_full,
  output logic [7:0]           out_byte,
  output ccfr_pkg::kind_t      out_kind,
  output ccfr_pkg::err_t       out_error_code,
  output logic [7:0]           out_payload_count,
  output logic                 out_empty,
  input  logic                 out_pop
);
  import ccfr_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(result_t);

  logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t    cmd_in, cmd_out;
  logic    res_push, res_full;
  result_t res_in, res_out;

  ccfr_front #(.MAX_RAW_BYTES(MAX_RAW_BYTES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_byte  (in_byte),
    .in_full  (in_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  ccfr_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  ccfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  ccfr_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_byte          = res_out.data;
  assign out_kind          = res_out.kind;
  assign out_error_code    = res_out.err;
  assign out_payload_count = res_out.payload_count;

endmodule

/* rtl/ccfr_checker.sv */
// Port-level checks for the COBS frame receiver, bound to the top level.
module ccfr_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_full,
  input logic [7:0]           out_byte,
  input ccfr_pkg::kind_t      out_kind,
  input ccfr_pkg::err_t       out_error_code,
  input logic [7:0]           out_payload_count,
  input logic                 out_empty,
  input logic                 out_pop
);
  import ccfr_pkg::*;

  // nothing can be waiting right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("result queue not empty after reset");

  // a waiting result holds until it is popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_byte) && $stable(out_kind)
      && $stable(out_error_code) && $stable(out_payload_count)))
    else $error("waiting result changed before transfer");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_kind == KIND_ID || out_kind == KIND_PAYLOAD))
      |-> (out_error_code == ERR_NONE && out_payload_count == 8'h00))
    else $error("id or payload result carries end-marker fields");

  a_end_code: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_kind == KIND_ACCEPT || out_kind == KIND_REJECT))
      |-> (out_byte == 8'h00 && ((out_kind == KIND_ACCEPT) == (out_error_code == ERR_NONE))))
    else $error("end marker kind disagrees with error code");

endmodule

bind cobs_crc8_frame_receiver ccfr_checker u_ccfr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_full           (in_full),
  .out_byte          (out_byte),
  .out_kind          (out_kind),
  .out_error_code    (out_error_code),
  .out_payload_count (out_payload_count),
  .out_empty         (out_empty),
  .out_pop           (out_pop)
);

/* sim/cobs_crc8_frame_receiver_tb.sv */
// Self-checking testbench for the COBS frame receiver: directed table, then random frames.
`timescale 1ns / 1ps

module cobs_crc8_frame_receiver_tb;
  import ccfr_pkg::*;

  localparam int RAW_LIMIT    = 255;
  localparam int RANDOM_BYTES = 1450;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    err_t       err;
    logic [7:0] count;
  } frame_event_t;

  typedef struct {
    logic [7:0]   b;
    bit           typed;
    frame_event_t ev;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic [7:0] in_byte;
  logic       in_push;
  logic       in_full;
  logic [7:0] out_byte;
  kind_t      out_kind;
  err_t       out_error_code;
  logic [7:0] out_payload_count;
  logic       out_empty;
  logic       out_pop;

  cobs_crc8_frame_receiver #(
    .MAX_RAW_BYTES(RAW_LIMIT)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_byte          (in_byte),
    .in_push          (in_push),
    .in_full          (in_full),
    .out_byte         (out_byte),
    .out_kind         (out_kind),
    .out_error_code   (out_error_code),
    .out_payload_count(out_payload_count),
    .out_empty        (out_empty),
    .out_pop          (out_pop)
  );

  // Decoder state mirror
  logic [7:0] blk_left;
  logic [7:0] raw_seen;
  logic [7:0] dec_seen;
  logic [7:0] crc_acc;
  logic [7:0] crc_rx;
  bit         zero_owed;
  err_t       fault;

  frame_event_t exp_q[$];
  dir_row_t     dir_q[$];
  logic [7:0]   msg_q[$];
  logic [7:0]   raw_q[$];

  int errors;
  int n_bytes;
  int rnd_bytes;
  int n_frames;
  int n_accept;
  int n_reject;
  int n_data;
  bit snd_burst;
  bit rcv_burst;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("cobs_crc8_frame_receiver: mismatch");
    $finish;
  end

  function automatic logic [7:0] crc_next(logic [7:0] crc, logic [7:0] v);
    logic [7:0] r;
    r = crc ^ v;
    repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
    return r;
  endfunction

  function automatic void reset_frame();
    blk_left  = 8'd0;
    raw_seen  = 8'd0;
    dec_seen  = 8'd0;
    crc_acc   = 8'd0;
    crc_rx    = 8'd0;
    zero_owed = 1'b0;
    fault     = ERR_NONE;
  endfunction

  // Decoded byte 0 is the received CRC; later bytes are id, then payload.
  function automatic void emit_decoded(logic [7:0] v);
    logic [7:0]   idx;
    frame_event_t ev;
    idx = dec_seen;
    if (dec_seen != COUNT_MAX) dec_seen = dec_seen + 8'd1;
    if (idx == 8'd0) begin
      crc_rx = v;
    end else begin
      crc_acc  = crc_next(crc_acc, v);
      ev.data  = v;
      ev.kind  = (idx == 8'd1) ? KIND_ID : KIND_PAYLOAD;
      ev.err   = ERR_NONE;
      ev.count = 8'd0;
      exp_q.push_back(ev);
      n_data++;
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    frame_event_t ev;
    if (b == 8'd0) begin
      ev.err = ERR_NONE;
      if (fault != ERR_NONE) ev.err = fault;
      else if (blk_left != 8'd0) ev.err = ERR_MALFORMED;
      else if (dec_seen < 8'd2) ev.err = ERR_SHORT;
      else if (crc_rx != crc_acc) ev.err = ERR_CRC;
      ev.data  = 8'd0;
      ev.kind  = (ev.err == ERR_NONE) ? KIND_ACCEPT : KIND_REJECT;
      ev.count = (dec_seen >= 8'd2) ? dec_seen - 8'd2 : 8'd0;
      exp_q.push_back(ev);
      n_frames++;
      if (ev.err == ERR_NONE) n_accept++;
      else n_reject++;
      reset_frame();
    end else if (fault == ERR_NONE) begin
      if (raw_seen >= 8'(RAW_LIMIT)) begin
        fault = ERR_OVERFLOW;
      end else begin
        raw_seen = raw_seen + 8'd1;
        if (blk_left == 8'd0) begin
          // code byte: release the zero owed by the previous short block
          if (zero_owed) emit_decoded(8'd0);
          blk_left  = b - 8'd1;
          zero_owed = (b != CODE_FULL);
        end else begin
          blk_left = blk_left - 8'd1;
          emit_decoded(b);
        end
      end
    end
  endfunction

  function automatic int draw_gap(bit burst);
    return burst ? 0 : int'($urandom_range(0, 17));
  endfunction

  task automatic push_byte(logic [7:0] b);
    int gap;
    if ($urandom_range(0, 63) == 0) snd_burst = !snd_burst;
    gap = draw_gap(snd_burst);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_byte <= b;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full !== 1'b0);
    n_bytes++;
  endtask

  task automatic feed(logic [7:0] b);
    push_byte(b);
    predict_byte(b);
    rnd_bytes++;
  endtask

  task automatic send_raw();
    foreach (raw_q[i]) feed(raw_q[i]);
    feed(8'd0);
  endtask

  // Hold the sender until every expected transfer has come out.
  task automatic wait_drained();
    in_push <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic dir_row(logic [7:0] b, bit typed, logic [7:0] data = 8'd0,
                         kind_t kind = KIND_ID, err_t err = ERR_NONE,
                         logic [7:0] cnt = 8'd0);
    dir_row_t row;
    row.b        = b;
    row.typed    = typed;
    row.ev.data  = data;
    row.ev.kind  = kind;
    row.ev.err   = err;
    row.ev.count = cnt;
    dir_q.push_back(row);
  endtask

  // Message: crc, id, payload; zero_pct controls zeros in id and payload.
  task automatic make_msg(int plen, int zero_pct, bit good_crc);
    logic [7:0] crc;
    int         i;
    msg_q.delete();
    msg_q.push_back(8'd0);
    for (i = 0; i <= plen; i++) begin
      if ($urandom_range(0, 99) < zero_pct) msg_q.push_back(8'd0);
      else msg_q.push_back(8'($urandom_range(1, 255)));
    end
    crc = 8'd0;
    for (i = 1; i < msg_q.size(); i++) crc = crc_next(crc, msg_q[i]);
    msg_q[0] = good_crc ? crc : crc ^ 8'($urandom_range(1, 255));
  endtask

  // COBS encode msg_q into raw_q; trim_full drops the 01 after a final full block.
  task automatic encode_msg(bit trim_full);
    logic [7:0] blk[$];
    int         code;
    bit         last_full;
    raw_q.delete();
    code      = 1;
    last_full = 1'b0;
    foreach (msg_q[i]) begin
      if (msg_q[i] == 8'd0) begin
        raw_q.push_back(8'(code));
        foreach (blk[j]) raw_q.push_back(blk[j]);
        blk.delete();
        code      = 1;
        last_full = 1'b0;
      end else begin
        blk.push_back(msg_q[i]);
        code++;
        if (code == 255) begin
          raw_q.push_back(CODE_FULL);
          foreach (blk[j]) raw_q.push_back(blk[j]);
          blk.delete();
          code      = 1;
          last_full = 1'b1;
        end
      end
    end
    if (!(trim_full && last_full && code == 1)) begin
      raw_q.push_back(8'(code));
      foreach (blk[j]) raw_q.push_back(blk[j]);
    end
  endtask

  // Mostly well-formed frames; the rest corrupted, cut short, split or noise.
  task automatic random_frame();
    int plen;
    int r;
    int pos;
    int keep;
    int n;
    plen = ($urandom_range(0, 9) == 0) ? int'($urandom_range(13, 60))
                                        : int'($urandom_range(0, 12));
    make_msg(plen, 25, $urandom_range(0, 99) < 85);
    if ($urandom_range(0, 19) == 0) begin
      n = $urandom_range(0, 1);
      while (msg_q.size() > n) void'(msg_q.pop_back());
    end
    encode_msg($urandom_range(0, 1) == 1);
    r   = $urandom_range(0, 99);
    pos = $urandom_range(0, raw_q.size() - 1);
    if (r >= 70 && r < 80) begin
      raw_q[pos] = 8'($urandom_range(0, 255));
    end else if (r >= 80 && r < 88) begin
      keep = $urandom_range(0, raw_q.size() - 1);
      while (raw_q.size() > keep) void'(raw_q.pop_back());
    end else if (r >= 88 && r < 95) begin
      raw_q.delete();
      n = $urandom_range(1, 10);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) raw_q.push_back(8'd0);
        else raw_q.push_back(8'($urandom_range(1, 255)));
      end
    end else if (r >= 95) begin
      raw_q.insert(pos, 8'd0);
    end
    send_raw();
  endtask

  task automatic check_result();
    frame_event_t ev;
    if (exp_q.size() == 0) begin
      errors++;
      $error("unexpected result: out_byte %0h out_kind %0d", out_byte, out_kind);
    end else begin
      ev = exp_q.pop_front();
      if (out_byte !== ev.data) begin
        errors++;
        $error("out_byte: expected %0h, got %0h", ev.data, out_byte);
      end
      if (out_kind !== ev.kind) begin
        errors++;
        $error("out_kind: expected %0d, got %0d", ev.kind, out_kind);
      end
      if (out_error_code !== ev.err) begin
        errors++;
        $error("out_error_code: expected %0d, got %0d", ev.err, out_error_code);
      end
      if (out_payload_count !== ev.count) begin
        errors++;
        $error("out_payload_count: expected %0d, got %0d", ev.count, out_payload_count);
      end
    end
  endtask

  // Result side: random pop stalls, checks each transfer against the oldest expectation.
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 63) == 0) rcv_burst = !rcv_burst;
      gap = draw_gap(rcv_burst);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty !== 1'b0);
      check_result();
    end
  end

  initial begin
    int prev_size;
    int frame_no;
    rst_n     <= 1'b0;
    in_push   <= 1'b0;
    in_byte   <= 8'd0;
    out_pop   <= 1'b0;
    errors    = 0;
    n_bytes   = 0;
    rnd_bytes = 0;
    n_frames  = 0;
    n_accept  = 0;
    n_reject  = 0;
    n_data    = 0;
    snd_burst = 1'b0;
    rcv_burst = 1'b0;
    reset_frame();

    // empty frame right after reset
    dir_row(8'h00, 1, 8'h00, KIND_REJECT, ERR_SHORT, 8'd0);
    // crc 00, id 00: three one-byte blocks, accepted
    dir_row(8'h01, 0);
    dir_row(8'h01, 0);
    dir_row(8'h01, 1, 8'h00, KIND_ID);
    dir_row(8'h00, 1, 8'h00, KIND_ACCEPT, ERR_NONE, 8'd0);
    // crc 01 against id 00
    dir_row(8'h02, 0);
    dir_row(8'h01, 0);
    dir_row(8'h01, 1, 8'h00, KIND_ID);
    dir_row(8'h00, 1, 8'h00, KIND_REJECT, ERR_CRC, 8'd0);
    // delimiter inside a block
    dir_row(8'h05, 0);
    dir_row(8'h11, 0);
    dir_row(8'h00, 1, 8'h00, KIND_REJECT, ERR_MALFORMED, 8'd0);
    // full code byte, frame cut inside the block
    dir_row(8'hff, 0);
    dir_row(8'haa, 0);
    dir_row(8'hbb, 1, 8'hbb, KIND_ID);
    dir_row(8'h00, 1, 8'h00, KIND_REJECT, ERR_MALFORMED, 8'd0);
    // payload with an implied zero released by the next code byte
    dir_row(8'h03, 0);
    dir_row(8'h5a, 0);
    dir_row(8'h80, 0);
    dir_row(8'h02, 0);
    dir_row(8'h7f, 0);
    dir_row(8'h00, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_q[i]) begin
      push_byte(dir_q[i].b);
      prev_size = exp_q.size();
      predict_byte(dir_q[i].b);
      if (dir_q[i].typed) begin
        if (exp_q.size() > prev_size) void'(exp_q.pop_back());
        exp_q.push_back(dir_q[i].ev);
      end
    end
    wait_drained();

    frame_no = 0;
    while (rnd_bytes < RANDOM_BYTES) begin
      case (frame_no)
        4, 9: begin
          // 254 non-zero decoded bytes: 255 raw bytes when trimmed, 256 (overflow) when not
          do make_msg(252, 0, 1'b1); while (msg_q[0] == 8'd0);
          encode_msg(frame_no == 4);
          send_raw();
        end
        14: begin
          make_msg(300, 20, 1'b1);
          encode_msg(1'b1);
          send_raw();
        end
        default: random_frame();
      endcase
      if (frame_no == 30) wait_drained();
      frame_no++;
    end

    in_push <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d bytes in %0d frames: %0d accepted, %0d rejected",
             n_bytes, n_frames, n_accept, n_reject);
    $display("checked %0d id/payload bytes plus every end marker, %0d errors",
             n_data, errors);
    if (errors == 0) begin
      $display("cobs_crc8_frame_receiver: match");
    end else begin
      $display("cobs_crc8_frame_receiver: mismatch");
    end
    $finish;
  end

endmodule

/* cobs_crc8_frame_receiver.f */
rtl/ccfr_pkg.sv
rtl/ccfr_fifo.sv
rtl/ccfr_front.sv
rtl/ccfr_back.sv
rtl/cobs_crc8_frame_receiver.sv
rtl/ccfr_checker.sv
sim/cobs_crc8_frame_receiver_tb.sv
